@@ rtl/gpl_pkg.sv @@
// Shared types and constants for the Gaussian-peak spectrum model unit.
// No dependencies; every other rtl file imports this package.
package gpl_pkg;

    // reciprocal 2^59 / |sigma|, one quotient bit per divider stage
    localparam int RECIP_BITS = 59;
    localparam int RECIP_W    = RECIP_BITS + 1;
    localparam int DIV_STAGES = RECIP_W;

    // exp(-u) table: 2048 steps of 1/64, stored as {e[k], e[k+1]} pairs
    localparam int ROM_STEP_BITS = 6;
    localparam int ROM_AW        = 11;
    localparam int ROM_LEN       = 1 << ROM_AW;
    localparam int ROM_DW        = 31;
    localparam logic [ROM_DW-1:0] ROM_ONE         = 31'd1073741824;
    localparam logic [30:0]       ROM_STEP_FACTOR = 31'd1057095000;

    // 1/sqrt(2*pi) in Q0.32
    localparam logic [30:0] INV_SQRT_2PI = 31'd1713444047;

    localparam int TERM_CAP_BIT = 40;
    localparam int TERM_W       = TERM_CAP_BIT + 2;

    // lane: two entry stages, the divider, nine arithmetic stages
    localparam int LANE_LAT = 2 + DIV_STAGES + 9;

    // result queue
    localparam int OQ_AW    = 7;
    localparam int OQ_DEPTH = 1 << OQ_AW;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_PEAK_COUNT   = 2'd0,
        CFG_COMMON_WIDTH = 2'd1,
        CFG_BIN_WIDTH    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                    en;
        logic [ROM_AW-1:0]       addr;
        logic [2*ROM_DW-1:0]     data;
    } t_rom_wr;

endpackage

@@ rtl/gpl_exp_fill.sv @@
// Table builder: computes exp(-k/64) pairs after reset and broadcasts writes.
// Depends on gpl_pkg.
module gpl_exp_fill import gpl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    output t_rom_wr o_rom_wr,
    output logic    o_done
);

    logic [ROM_AW-1:0]   r_addr;
    logic [ROM_DW-1:0]   r_val;
    logic                r_busy;
    logic [2*ROM_DW-1:0] w_prod;
    logic [ROM_DW-1:0]   n_val;

    // e[k+1] = round(e[k] * exp(-1/64))
    assign w_prod = r_val * ROM_STEP_FACTOR;
    assign n_val  = ROM_DW'((w_prod + (62'd1 << 29)) >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
            r_val  <= ROM_ONE;
        end else if (r_busy) begin
            r_val  <= n_val;
            r_addr <= r_addr + 1'b1;
            if (r_addr == ROM_AW'(ROM_LEN - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rom_wr.en   = r_busy;
    assign o_rom_wr.addr = r_addr;
    assign o_rom_wr.data = {r_val, n_val};
    assign o_done        = !r_busy;

endmodule

@@ rtl/gpl_recip.sv @@
// Pipelined restoring divider: 2^59 / divisor, one quotient bit per stage.
// Depends on gpl_pkg; carries a side bundle alongside.
module gpl_recip import gpl_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_divisor,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [RECIP_W-1:0] o_quot,
    output logic [SIDE_W-1:0]  o_side
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [31:0]           r_rem  [0:DIV_STAGES-1];
    logic [RECIP_W-1:0]    r_quo  [0:DIV_STAGES-1];
    logic [31:0]           r_dvs  [0:DIV_STAGES-1];
    logic [SIDE_W-1:0]     r_side [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        // dividend is 2^59: only the first step shifts in a one
        localparam logic DIVIDEND_BIT = (k == 0);
        logic [31:0]        w_rem_in;
        logic [RECIP_W-1:0] w_quo_in;
        logic [31:0]        w_dvs_in;
        logic [SIDE_W-1:0]  w_side_in;
        logic               w_vld_in;
        logic [32:0]        w_trial;
        logic [32:0]        w_diff;
        logic               w_fit;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_quo_in  = '0;
            assign w_dvs_in  = i_divisor;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_dvs_in  = r_dvs[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_trial = {w_rem_in, DIVIDEND_BIT};
        assign w_diff  = w_trial - {1'b0, w_dvs_in};
        assign w_fit   = (w_trial >= {1'b0, w_dvs_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_fit ? w_diff[31:0] : w_trial[31:0];
            r_quo[k]  <= {w_quo_in[RECIP_W-2:0], w_fit};
            r_dvs[k]  <= w_dvs_in;
            r_side[k] <= w_side_in;
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_quo[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

@@ rtl/gpl_lane.sv @@
// One peak lane: distance, reciprocal, exp table lookup and amplitude chain.
// Depends on gpl_pkg and gpl_recip; holds its own copy of the exp table.
module gpl_lane import gpl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_rom_wr                  i_rom_wr,
    input  logic                     i_valid,
    input  logic                     i_active,
    input  logic signed [31:0]       i_x,
    input  logic signed [31:0]       i_content,
    input  logic signed [31:0]       i_centre,
    input  logic signed [31:0]       i_sigma,
    input  logic [30:0]              i_bin_width,
    output logic                     o_valid,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int SH    = FRAC_BITS - ROM_STEP_BITS;
    localparam int Z_W   = FRAC_BITS + 3;
    localparam int U_W   = FRAC_BITS + 5;
    localparam int Z_LSB = RECIP_BITS - FRAC_BITS;
    localparam int P3_W  = 61 - FRAC_BITS;
    localparam int P3H_W = P3_W - 32;
    localparam int RH_W  = RECIP_W - 32;
    localparam int PR_W  = P3_W + RECIP_W;

    typedef struct packed {
        logic [32:0] dm;
        logic [29:0] p1;
        logic        kill;
        logic        neg;
    } t_side;
    localparam int SIDE_W = $bits(t_side);

    // ---------------- entry stages ----------------
    logic               r_e0_vld;
    logic signed [32:0] r_e0_diff;
    logic [31:0]        r_e0_c;
    logic [31:0]        r_e0_s;
    logic               r_e0_act;

    logic               r_e1_vld;
    logic [32:0]        r_e1_dm;
    logic [31:0]        r_e1_cm;
    logic [31:0]        r_e1_sm;
    logic               r_e1_kill;
    logic               r_e1_neg;

    logic [62:0]        w_p1_prod;
    logic               w_tail;
    t_side              w_side_in;
    t_side              w_side_out;
    logic [SIDE_W-1:0]  w_side_vec;
    logic               w_d_vld;
    logic [RECIP_W-1:0] w_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_vld <= 1'b0;
            r_e1_vld <= 1'b0;
        end else begin
            r_e0_vld <= i_valid;
            r_e1_vld <= r_e0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0_diff <= {i_x[31], i_x} - {i_centre[31], i_centre};
        r_e0_c    <= i_content;
        r_e0_s    <= i_sigma;
        r_e0_act  <= i_active;
        r_e1_dm   <= r_e0_diff[32] ? 33'(-r_e0_diff) : 33'(r_e0_diff);
        r_e1_cm   <= r_e0_c[31] ? -r_e0_c : r_e0_c;
        r_e1_sm   <= r_e0_s[31] ? -r_e0_s : r_e0_s;
        r_e1_kill <= (r_e0_s == '0) || !r_e0_act;
        r_e1_neg  <= r_e0_c[31] ^ r_e0_s[31];
    end

    // far tail: |x - centre| >= 8 sigma contributes nothing
    assign w_tail    = ({2'b00, r_e1_dm} >= {r_e1_sm, 3'b000});
    assign w_p1_prod = r_e1_cm * INV_SQRT_2PI;

    assign w_side_in.dm   = r_e1_dm;
    assign w_side_in.p1   = w_p1_prod[61:32];
    assign w_side_in.kill = r_e1_kill || w_tail;
    assign w_side_in.neg  = r_e1_neg;

    gpl_recip #(
        .SIDE_W (SIDE_W)
    ) u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_e1_vld),
        .i_divisor (r_e1_sm),
        .i_side    (w_side_in),
        .o_valid   (w_d_vld),
        .o_quot    (w_recip),
        .o_side    (w_side_vec)
    );
    assign w_side_out = t_side'(w_side_vec);

    // ---------------- arithmetic stages ----------------
    logic [8:0]            r_vld_s;
    logic [RECIP_W-1:0]    r_r   [1:8];
    logic [29:0]           r_p1  [1:5];
    logic                  r_kill[1:8];
    logic                  r_neg [1:8];

    logic [64:0]           r_s1_lo;
    logic [60:0]           r_s1_hi;
    logic [63:0]           w_pz;
    logic [Z_W-1:0]        r_s2_z;
    logic [2*Z_W-1:0]      w_zz;
    logic [U_W-1:0]        w_u;
    logic [ROM_AW-1:0]     r_s3_idx;
    logic [SH-1:0]         r_s3_f;
    logic [2*ROM_DW-1:0]   r_s4_word;
    logic [SH-1:0]         r_s4_f;
    logic [ROM_DW-1:0]     w_a;
    logic [ROM_DW-1:0]     w_b;
    logic [ROM_DW-1:0]     w_ab;
    logic [ROM_DW+SH-1:0]  w_ip;
    logic [ROM_DW-1:0]     r_s5_g;
    logic [60:0]           w_p2_prod;
    logic [29:0]           r_s6_p2;
    logic [60:0]           w_p3_prod;
    logic [P3_W-1:0]       r_s7_p3;
    logic [63:0]           r_s8_ll;
    logic [32+RH_W-1:0]    r_s8_lh;
    logic [P3H_W+31:0]     r_s8_hl;
    logic [P3H_W+RH_W-1:0] r_s8_hh;
    logic [PR_W-1:0]       w_full;
    logic                  w_ovf;
    logic [TERM_W-2:0]     w_mag;
    logic signed [TERM_W-1:0] w_mag_s;
    logic signed [TERM_W-1:0] r_s9_term;

    logic [2*ROM_DW-1:0]   r_rom [0:ROM_LEN-1];

    always_ff @(posedge i_clk) begin
        if (i_rom_wr.en) begin
            r_rom[i_rom_wr.addr] <= i_rom_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s <= '0;
        end else begin
            r_vld_s <= {r_vld_s[7:0], w_d_vld};
        end
    end

    assign w_pz = r_s1_lo[63:0] + {r_s1_hi[31:0], 32'b0};
    assign w_zz = r_s2_z * r_s2_z;
    assign w_u  = w_zz[FRAC_BITS+1 +: U_W];

    assign w_a  = r_s4_word[2*ROM_DW-1:ROM_DW];
    assign w_b  = r_s4_word[ROM_DW-1:0];
    assign w_ab = w_a - w_b;
    assign w_ip = w_ab * r_s4_f;

    assign w_p2_prod = r_p1[5] * r_s5_g;
    assign w_p3_prod = r_s6_p2 * i_bin_width;

    assign w_full = PR_W'(r_s8_ll)
                  + (PR_W'(r_s8_lh) << 32)
                  + (PR_W'(r_s8_hl) << 32)
                  + (PR_W'(r_s8_hh) << 64);
    // product past 64 bits means the term is capped
    assign w_ovf   = |w_full[PR_W-1:64];
    assign w_mag   = w_ovf ? ((TERM_W-1)'(1) << TERM_CAP_BIT)
                           : (TERM_W-1)'(w_full[63:Z_LSB]);
    assign w_mag_s = signed'({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        // S1: |d| * r in two halves
        r_s1_lo   <= w_side_out.dm * w_recip[31:0];
        r_s1_hi   <= w_side_out.dm * w_recip[RECIP_W-1:32];
        r_r[1]    <= w_recip;
        r_p1[1]   <= w_side_out.p1;
        r_kill[1] <= w_side_out.kill;
        r_neg[1]  <= w_side_out.neg;
        // S2: z = |x-centre|/sigma
        r_s2_z    <= w_pz[Z_LSB+Z_W-1:Z_LSB];
        // S3: u = z^2/2, split into table index and fraction
        r_s3_idx  <= w_u[U_W-1 -: ROM_AW];
        r_s3_f    <= w_u[SH-1:0];
        // S4: table read
        r_s4_word <= r_rom[r_s3_idx];
        r_s4_f    <= r_s3_f;
        // S5: linear interpolation
        r_s5_g    <= w_a - ROM_DW'(w_ip >> SH);
        // S6, S7: amplitude chain
        r_s6_p2   <= w_p2_prod[59:30];
        r_s7_p3   <= w_p3_prod[60:FRAC_BITS];
        // S8: partial products of p3 * r
        r_s8_ll   <= r_s7_p3[31:0] * r_r[7][31:0];
        r_s8_lh   <= r_s7_p3[31:0] * r_r[7][RECIP_W-1:32];
        r_s8_hl   <= r_s7_p3[P3_W-1:32] * r_r[7][31:0];
        r_s8_hh   <= r_s7_p3[P3_W-1:32] * r_r[7][RECIP_W-1:32];
        // S9: assemble, cap, sign
        if (r_kill[8]) begin
            r_s9_term <= '0;
        end else begin
            r_s9_term <= r_neg[8] ? -w_mag_s : w_mag_s;
        end
    end

    for (genvar s = 2; s <= 8; s++) begin : g_carry
        always_ff @(posedge i_clk) begin
            r_r[s]    <= r_r[s-1];
            r_kill[s] <= r_kill[s-1];
            r_neg[s]  <= r_neg[s-1];
        end
    end

    for (genvar s = 2; s <= 5; s++) begin : g_carry_p1
        always_ff @(posedge i_clk) begin
            r_p1[s] <= r_p1[s-1];
        end
    end

    assign o_valid = r_vld_s[8];
    assign o_term  = r_s9_term;

endmodule

@@ rtl/gpl_merge.sv @@
// Merge stage: linear background path, sum of lane terms and saturation.
// Depends on gpl_pkg.
module gpl_merge import gpl_pkg::*; #(
    parameter int MAX_PEAKS = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [31:0]       i_x,
    input  logic signed [31:0]       i_bg_constant,
    input  logic signed [31:0]       i_bg_slope,
    input  logic [MAX_PEAKS-1:0]     i_lane_valid,
    input  logic signed [TERM_W-1:0] i_terms [MAX_PEAKS],
    output logic                     o_valid,
    output logic signed [31:0]       o_value,
    output logic                     o_sat
);

    localparam int BG_W   = 65 - FRAC_BITS;
    localparam int ACC_W  = ((BG_W > TERM_W) ? BG_W : TERM_W) + 2;
    localparam int BG_DLY = LANE_LAT - 2;

    logic signed [63:0]    w_prod;
    logic signed [63:0]    r_b0_prod;
    logic signed [31:0]    r_b0_const;
    logic signed [BG_W-1:0] r_dly [0:BG_DLY];
    logic signed [ACC_W-1:0] w_acc;
    logic                  w_hi;
    logic                  w_lo;

    assign w_prod = i_bg_slope * i_x;

    always_ff @(posedge i_clk) begin
        r_b0_prod  <= w_prod;
        r_b0_const <= i_bg_constant;
        // floor division by 2^F
        r_dly[0]   <= BG_W'(r_b0_const) + BG_W'(r_b0_prod >>> FRAC_BITS);
    end

    for (genvar d = 1; d <= BG_DLY; d++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dly[d] <= r_dly[d-1];
        end
    end

    always_comb begin
        w_acc = ACC_W'(r_dly[BG_DLY]);
        for (int p = 0; p < MAX_PEAKS; p++) begin
            w_acc = w_acc + ACC_W'(i_terms[p]);
        end
    end

    assign w_hi = (w_acc > ACC_W'(SAT_MAX));
    assign w_lo = (w_acc < ACC_W'(SAT_MIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= &i_lane_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_sat <= w_hi || w_lo;
        if (w_hi) begin
            o_value <= SAT_MAX;
        end else if (w_lo) begin
            o_value <= SAT_MIN;
        end else begin
            o_value <= w_acc[31:0];
        end
    end

endmodule

@@ rtl/gaussian_peaks_with_linear_background_unit.sv @@
// Top level of the spectrum model unit: linear background plus Gaussian peaks.
// Depends on gpl_pkg, gpl_exp_fill, gpl_lane, gpl_merge.
//
// Usage
//   Request channel: i_in_valid / o_in_ready, fields i_x_position .. i_width_c,
//   all signed Q16.16. A request is taken on a clock edge with both high.
//   Result channel: o_out_valid / i_out_ready, o_model_value (signed Q16.16,
//   clipped to 32 bits) and o_saturated, one result per request, in order.
//   Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
//   (0 peak count, 1 common width, 2 bin width) on that edge; other indexes
//   are dropped. Write only while no request is in flight.
// Timing
//   One request per cycle sustained while o_in_ready is high. A request passes
//   two entry stages, the 60-stage reciprocal pipeline (one quotient bit per
//   stage), nine multiply/lookup stages, the merge stage, the result queue and
//   its output register on its way to o_out_valid.
// Reset
//   i_rst_n is synchronous. After reset every lane's exp table is rebuilt,
//   one entry per cycle; o_in_ready stays low until the build is done. Config
//   writes are taken meanwhile.
// Back pressure
//   Results land in a 128-entry queue; requests are taken while the count of
//   requests in flight plus queued results is below its depth, so a stalled
//   receiver only blocks the request side once the queue is full.
module gaussian_peaks_with_linear_background_unit import gpl_pkg::*; #(
    parameter int MAX_PEAKS = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_position,
    input  logic signed [31:0] i_bg_constant,
    input  logic signed [31:0] i_bg_slope,
    input  logic signed [31:0] i_content_a,
    input  logic signed [31:0] i_centre_a,
    input  logic signed [31:0] i_width_a,
    input  logic signed [31:0] i_content_b,
    input  logic signed [31:0] i_centre_b,
    input  logic signed [31:0] i_width_b,
    input  logic signed [31:0] i_content_c,
    input  logic signed [31:0] i_centre_c,
    input  logic signed [31:0] i_width_c,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_model_value,
    output logic               o_saturated
);

    localparam int OQ_CW = OQ_AW + 1;

    // ---------------- configuration ----------------
    logic [1:0]  r_peak_count;
    logic        r_common_width;
    logic [30:0] r_bin_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_count   <= 2'd1;
            r_common_width <= 1'b0;
            r_bin_width    <= 31'(1 << FRAC_BITS);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PEAK_COUNT: begin
                    r_peak_count <= i_cfg_data[1:0];
                end
                CFG_COMMON_WIDTH: begin
                    r_common_width <= i_cfg_data[0];
                end
                CFG_BIN_WIDTH: begin
                    r_bin_width <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- table build ----------------
    t_rom_wr w_rom_wr;
    logic    w_fill_done;

    gpl_exp_fill u_fill (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_rom_wr (w_rom_wr),
        .o_done   (w_fill_done)
    );

    // ---------------- request side ----------------
    logic [OQ_CW-1:0] r_used;
    logic             w_in_acc;
    logic             w_out_acc;
    logic [1:0]       w_eff_count;

    assign o_in_ready  = w_fill_done && (r_used < OQ_CW'(OQ_DEPTH));
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    // counts above the lane count fall back to the lane count
    assign w_eff_count = (r_peak_count > 2'(MAX_PEAKS)) ? 2'(MAX_PEAKS) : r_peak_count;

    logic signed [31:0] w_content [0:2];
    logic signed [31:0] w_centre  [0:2];
    logic signed [31:0] w_width   [0:2];

    assign w_content[0] = i_content_a;
    assign w_content[1] = i_content_b;
    assign w_content[2] = i_content_c;
    assign w_centre[0]  = i_centre_a;
    assign w_centre[1]  = i_centre_b;
    assign w_centre[2]  = i_centre_c;
    assign w_width[0]   = i_width_a;
    assign w_width[1]   = i_width_b;
    assign w_width[2]   = i_width_c;

    // ---------------- peak lanes ----------------
    logic [MAX_PEAKS-1:0]     w_lane_vld;
    logic signed [TERM_W-1:0] w_term [MAX_PEAKS];

    for (genvar p = 0; p < MAX_PEAKS; p++) begin : g_lane
        logic signed [31:0] w_sigma;
        logic               w_active;

        // common-width mode reuses peak zero's sigma everywhere
        assign w_sigma  = r_common_width ? i_width_a : w_width[p];
        assign w_active = (2'(p) < w_eff_count);

        gpl_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rom_wr    (w_rom_wr),
            .i_valid     (w_in_acc),
            .i_active    (w_active),
            .i_x         (i_x_position),
            .i_content   (w_content[p]),
            .i_centre    (w_centre[p]),
            .i_sigma     (w_sigma),
            .i_bin_width (r_bin_width),
            .o_valid     (w_lane_vld[p]),
            .o_term      (w_term[p])
        );
    end

    // ---------------- merge ----------------
    logic               w_m_vld;
    logic signed [31:0] w_m_value;
    logic               w_m_sat;

    gpl_merge #(
        .MAX_PEAKS (MAX_PEAKS),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_x           (i_x_position),
        .i_bg_constant (i_bg_constant),
        .i_bg_slope    (i_bg_slope),
        .i_lane_valid  (w_lane_vld),
        .i_terms       (w_term),
        .o_valid       (w_m_vld),
        .o_value       (w_m_value),
        .o_sat         (w_m_sat)
    );

    // ---------------- result queue ----------------
    logic [32:0]      r_oq_mem [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0] r_wr_ptr;
    logic [OQ_AW-1:0] r_rd_ptr;
    logic [OQ_CW-1:0] r_mem_cnt;
    logic             r_out_vld;
    logic [32:0]      r_out_data;
    logic             w_load;

    // refill the output register whenever the queue holds a result and the register is empty or being taken
    assign w_load = (r_mem_cnt != '0) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_mem_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_used    <= r_used + OQ_CW'(w_in_acc) - OQ_CW'(w_out_acc);
            r_mem_cnt <= r_mem_cnt + OQ_CW'(w_m_vld) - OQ_CW'(w_load);
            if (w_m_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_load) begin
                r_rd_ptr  <= r_rd_ptr + 1'b1;
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_vld) begin
            r_oq_mem[r_wr_ptr] <= {w_m_sat, w_m_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_oq_mem[r_rd_ptr];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_model_value = r_out_data[31:0];
    assign o_saturated   = r_out_data[32];

endmodule

@@ rtl/gpl_check.sv @@
// Port-level checks for the spectrum model unit, bound to the top level.
// Depends on gpl_pkg and gaussian_peaks_with_linear_background_unit.
module gpl_check import gpl_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_model_value,
    input logic               o_saturated
);

    // table rebuild blocks requests right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request accepted right after reset");

    // no result can be pending right after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // clipped results sit at a range limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_model_value == SAT_MAX || o_model_value == SAT_MIN))
        else $error("saturation flag without a limit value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_model_value) && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind gaussian_peaks_with_linear_background_unit gpl_check u_gpl_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_model_value (o_model_value),
    .o_saturated   (o_saturated)
);
